// ===== src/obms_pkg.sv =====
// ---------------------------------------------------------------------------
// obms_pkg: shared definitions for the one-button menu selector
// Slot count, field widths, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package obms_pkg;

	// Slot geometry.
	localparam int SLOT_COUNT = 4;
	localparam int MASK_W     = 4;
	localparam int SLOT_W     = 2;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [MASK_W-1:0]    mask_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_VALID_MASK   = 3'd0;
	localparam cfg_idx_t REG_START_CURSOR = 3'd1;
	localparam cfg_idx_t REG_LONG_PRESS   = 3'd2;
	localparam cfg_idx_t REG_DEBOUNCE     = 3'd3;
	localparam cfg_idx_t REG_AUTOBOOT     = 3'd4;
	localparam cfg_idx_t REG_AUTO_ENABLE  = 3'd5;

	// Reset values of the configuration registers.
	localparam mask_t RST_VALID_MASK   = 4'hF;
	localparam slot_t RST_START_CURSOR = 2'd0;
	localparam cnt_t  RST_LONG_PRESS   = 16'd700;
	localparam cnt_t  RST_DEBOUNCE     = 16'd40;
	localparam cnt_t  RST_AUTOBOOT     = 16'd6000;
	localparam logic  RST_AUTO_ENABLE  = 1'b1;

	localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== src/one_button_menu_selector_top.sv =====
// ---------------------------------------------------------------------------
// one_button_menu_selector_top: one-button boot menu selector
// Tracks short and long presses of a single button, moves a slot cursor and
// raises a boot request on a long press or when the autoboot countdown ends.
// ---------------------------------------------------------------------------
// Each request is one millisecond tick carrying the button level and yields
// exactly one result: the cursor, the boot request flag, the autoboot flag
// and the ticks left on the countdown. A request is taken every clock cycle
// while the input is not stalled; the press and autoboot state update in one
// pass of short compare and add logic into the state registers and the result
// register, and a result that waits to be taken stalls the input only while
// the result register is full and not being drained. After a boot request the
// block ignores the button until reset. Configuration is written through a
// plain write port and should only change while the block is idle.
`default_nettype none

module one_button_menu_selector_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire obms_pkg::cfg_idx_t            cfg_index,
	input  wire logic [obms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          button_down,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output obms_pkg::slot_t                    cursor,
	output logic                               boot_request,
	output logic                               autoboot_active,
	output obms_pkg::cnt_t                     ticks_left
);
	import obms_pkg::*;

	// Configuration registers.
	mask_t valid_mask_q;
	cnt_t  long_press_q;
	cnt_t  debounce_q;
	cnt_t  autoboot_q;

	// Press and autoboot state.
	slot_t sel_slot_q;
	logic  held_q;
	logic  long_done_q;
	cnt_t  press_count_q;
	logic  auto_on_q;
	cnt_t  auto_count_q;
	logic  halted_q;

	// Result register.
	logic  out_valid_q;
	slot_t cursor_q;
	logic  boot_q;
	logic  active_q;
	cnt_t  left_q;

	// Next-state and result values for one request.
	slot_t sel_n;
	slot_t next_slot;
	logic  held_n;
	logic  long_n;
	cnt_t  press_n;
	logic  auto_n;
	cnt_t  auto_cnt_n;
	logic  halted_n;
	logic  boot_n;
	cnt_t  left_n;
	logic  in_accept;

	// The result register frees when empty or when its result is taken.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// Next valid slot after the cursor; the nearest step wins, the cursor
	// stays where it is when no other slot is valid.
	always_comb begin
		logic [SLOT_W:0] sum;
		logic [SLOT_W:0] cand;
		next_slot = sel_slot_q;
		for (int step = SLOT_COUNT; step >= 1; step--) begin
			sum  = {1'b0, sel_slot_q} + (SLOT_W+1)'(step);
			cand = (sum >= (SLOT_W+1)'(SLOT_COUNT)) ? sum - (SLOT_W+1)'(SLOT_COUNT) : sum;
			if ((cand < (SLOT_W+1)'(SLOT_COUNT)) && (cand < (SLOT_W+1)'(MASK_W)) &&
				valid_mask_q[cand[SLOT_W-1:0]]) begin
				next_slot = cand[SLOT_W-1:0];
			end
		end
	end

	// One tick of press tracking and autoboot countdown.
	always_comb begin
		sel_n      = sel_slot_q;
		held_n     = held_q;
		long_n     = long_done_q;
		press_n    = press_count_q;
		auto_n     = auto_on_q;
		auto_cnt_n = auto_count_q;
		halted_n   = halted_q;
		boot_n     = 1'b0;
		left_n     = '0;
		if (!halted_q) begin
			if (held_q && (press_count_q != CNT_MAX)) begin
				press_n = press_count_q + cnt_t'(1);
			end
			priority if (button_down && !held_q) begin
				press_n = '0;
				held_n  = 1'b1;
				long_n  = 1'b0;
				auto_n  = 1'b0;
			end else if (button_down && !long_done_q && (press_n >= long_press_q)) begin
				long_n = 1'b1;
				boot_n = 1'b1;
			end else if (!button_down && held_q) begin
				held_n = 1'b0;
				if (!long_done_q && (press_n >= debounce_q)) begin
					sel_n = next_slot;
				end
			end else begin
				held_n = held_q;
			end
			if (!boot_n && auto_n) begin
				if (auto_count_q >= autoboot_q) begin
					boot_n = 1'b1;
				end else begin
					left_n = autoboot_q - auto_count_q;
					if (auto_count_q != CNT_MAX) begin
						auto_cnt_n = auto_count_q + cnt_t'(1);
					end
				end
			end
			if (boot_n) begin
				halted_n = 1'b1;
				auto_n   = 1'b0;
				left_n   = '0;
			end
		end
	end

	// Configuration, state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_mask_q   <= RST_VALID_MASK;
			long_press_q   <= RST_LONG_PRESS;
			debounce_q     <= RST_DEBOUNCE;
			autoboot_q     <= RST_AUTOBOOT;
			sel_slot_q     <= RST_START_CURSOR;
			held_q         <= 1'b0;
			long_done_q    <= 1'b0;
			press_count_q  <= '0;
			auto_on_q      <= RST_AUTO_ENABLE;
			auto_count_q   <= '0;
			halted_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VALID_MASK: begin
						valid_mask_q <= cfg_data[MASK_W-1:0];
					end
					REG_START_CURSOR: begin
						if (!halted_q) begin
							sel_slot_q <= cfg_data[SLOT_W-1:0];
						end
					end
					REG_LONG_PRESS: begin
						long_press_q <= cfg_data[CNT_W-1:0];
					end
					REG_DEBOUNCE: begin
						debounce_q <= cfg_data[CNT_W-1:0];
					end
					REG_AUTOBOOT: begin
						autoboot_q <= cfg_data[CNT_W-1:0];
					end
					REG_AUTO_ENABLE: begin
						if (!halted_q) begin
							auto_on_q    <= cfg_data[0];
							auto_count_q <= '0;
						end
					end
					default: begin
						valid_mask_q <= valid_mask_q;
					end
				endcase
			end else if (in_accept) begin
				sel_slot_q    <= sel_n;
				held_q        <= held_n;
				long_done_q   <= long_n;
				press_count_q <= press_n;
				auto_on_q     <= auto_n;
				auto_count_q  <= auto_cnt_n;
				halted_q      <= halted_n;
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cursor_q <= sel_n;
			boot_q   <= boot_n;
			active_q <= !halted_n && auto_n;
			left_q   <= left_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor          = cursor_q;
	assign boot_request    = boot_q;
	assign autoboot_active = active_q;
	assign ticks_left      = left_q;

`ifndef SYNTHESIS
	// A boot result never shows a running countdown.
	a_boot_clears_auto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && boot_request |-> !autoboot_active && (ticks_left == '0))
		else $error("boot result shows a running countdown");

	// A running countdown always has ticks left.
	a_active_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && autoboot_active |-> (ticks_left != '0))
		else $error("countdown running with no ticks left");

	// Once halted, the block stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	// No request taken while halted raises a boot.
	a_halt_no_boot: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && in_accept |=> !boot_request)
		else $error("boot raised while halted");

	// The countdown is never running once halted.
	a_halt_no_auto: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !auto_on_q)
		else $error("countdown running while halted");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_one_button_menu_selector_top.sv =====
// ---------------------------------------------------------------------------
// tb_one_button_menu_selector_top: testbench of the one-button menu selector
// A short table of directed ticks and register writes, then random press
// sequences over many register settings and four idling phases, and a single
// boot at the very end followed by ticks into the halted block. Every result
// is checked against literals or a cycle-free selector model in this file.
// ---------------------------------------------------------------------------
module tb_one_button_menu_selector_top;
	timeunit 1ns;
	timeprecision 1ps;

	import obms_pkg::*;

	localparam int RAND_TICKS   = 1100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;

	// One result of the selector.
	typedef struct packed {
		slot_t cursor;
		logic  boot;
		logic  active;
		cnt_t  left;
	} tick_res_t;

	typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		cfg_idx_t            idx;
		logic [CFG_DATA_W-1:0] data;
		logic                down;
		bit                  lit;
		tick_res_t           res;
	} dir_row_t;

	typedef enum int {BOOT_BY_HOLD, BOOT_BY_TIMEOUT, BOOT_ZERO_HOLD, BOOT_ZERO_TIMEOUT}
		boot_path_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  button_down;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	slot_t                 cursor;
	logic                  boot_request;
	logic                  autoboot_active;
	cnt_t                  ticks_left;

	// Model copy of the registers, loaded with their reset values.
	mask_t cfg_mask     = RST_VALID_MASK;
	slot_t cfg_start    = RST_START_CURSOR;
	cnt_t  cfg_hold     = RST_LONG_PRESS;
	cnt_t  cfg_debounce = RST_DEBOUNCE;
	cnt_t  cfg_autoboot = RST_AUTOBOOT;

	// Model copy of the press and countdown state.
	slot_t st_slot      = RST_START_CURSOR;
	logic  st_held      = 1'b0;
	logic  st_hold_done = 1'b0;
	cnt_t  st_press     = '0;
	logic  st_auto_on   = RST_AUTO_ENABLE;
	cnt_t  st_auto_cnt  = '0;
	logic  st_halted    = 1'b0;

	tick_res_t pending_results[$];
	dir_row_t  dir_rows[$];

	int        send_idle   = 0;
	int        recv_stall  = 0;
	int        ticks_sent  = 0;
	int        mismatches  = 0;
	int        cycle_count = 0;
	bit        cur_lit     = 1'b0;
	tick_res_t cur_lit_res = '0;
	tick_res_t predicted;
	tick_res_t oldest;

	one_button_menu_selector_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.button_down     (button_down),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cursor          (cursor),
		.boot_request    (boot_request),
		.autoboot_active (autoboot_active),
		.ticks_left      (ticks_left)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Advances the model by one tick and returns the result it gives.
	function automatic tick_res_t predict_tick(input logic down);
		tick_res_t r;
		logic      boot;
		cnt_t      left;
		int        cand;
		bit        found;
		boot  = 1'b0;
		left  = '0;
		found = 1'b0;
		if (!st_halted) begin
			if (st_held && st_press != CNT_MAX)
				st_press++;
			if (down && !st_held) begin
				// A press edge cancels the countdown on the same tick.
				st_press     = '0;
				st_held      = 1'b1;
				st_hold_done = 1'b0;
				st_auto_on   = 1'b0;
			end else if (down && st_held && !st_hold_done && st_press >= cfg_hold) begin
				st_hold_done = 1'b1;
				boot         = 1'b1;
			end else if (!down && st_held) begin
				st_held = 1'b0;
				// A short press walks to the next valid slot, wrapping round.
				if (!st_hold_done && st_press >= cfg_debounce) begin
					for (int step = 1; step <= SLOT_COUNT; step++) begin
						cand = (int'(st_slot) + step) % SLOT_COUNT;
						if (!found && cand < MASK_W && cfg_mask[cand]) begin
							st_slot = slot_t'(cand);
							found   = 1'b1;
						end
					end
				end
			end
			if (!boot && st_auto_on) begin
				if (st_auto_cnt >= cfg_autoboot) begin
					boot = 1'b1;
				end else begin
					left = cfg_autoboot - st_auto_cnt;
					if (st_auto_cnt != CNT_MAX)
						st_auto_cnt++;
				end
			end
			if (boot) begin
				st_halted  = 1'b1;
				st_auto_on = 1'b0;
				left       = '0;
			end
		end
		r.cursor = st_slot;
		r.boot   = boot;
		r.active = !st_halted && st_auto_on;
		r.left   = left;
		return r;
	endfunction

	// Writes one register once every result is out, and updates the model.
	task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			REG_VALID_MASK: cfg_mask = val[MASK_W-1:0];
			REG_START_CURSOR: begin
				cfg_start = val[SLOT_W-1:0];
				if (!st_halted)
					st_slot = cfg_start;
			end
			REG_LONG_PRESS: cfg_hold     = val;
			REG_DEBOUNCE:   cfg_debounce = val;
			REG_AUTOBOOT:   cfg_autoboot = val;
			REG_AUTO_ENABLE: begin
				if (!st_halted) begin
					st_auto_on  = val[0];
					st_auto_cnt = '0;
				end
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offers one tick request after a random gap and waits for it to be taken.
	task automatic send_tick(input logic down, input bit lit, input tick_res_t lit_res);
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		button_down = down;
		cur_lit     = lit;
		cur_lit_res = lit_res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic row_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		dir_rows.push_back('{ROW_CFG, idx, val, 1'b0, 1'b0, '0});
	endtask

	task automatic row_tick(input logic down);
		dir_rows.push_back('{ROW_TICK, REG_VALID_MASK, '0, down, 1'b0, '0});
	endtask

	task automatic row_tick_lit(input logic down, input slot_t cur, input logic boot,
			input logic active, input cnt_t left);
		tick_res_t r;
		r = '{cur, boot, active, left};
		dir_rows.push_back('{ROW_TICK, REG_VALID_MASK, '0, down, 1'b1, r});
	endtask

	// Receiver stalls.
	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_stall);
	end

	// Predicts each accepted request and checks each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = predict_tick(button_down);
				if (cur_lit)
					pending_results.push_back(cur_lit_res);
				else
					pending_results.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: cursor %0d boot %0d",
						cursor, boot_request);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					if (cursor !== oldest.cursor) begin
						$error("cursor: expected %0d, got %0d", oldest.cursor, cursor);
						mismatches++;
					end
					if (boot_request !== oldest.boot) begin
						$error("boot_request: expected %0d, got %0d", oldest.boot,
							boot_request);
						mismatches++;
					end
					if (autoboot_active !== oldest.active) begin
						$error("autoboot_active: expected %0d, got %0d", oldest.active,
							autoboot_active);
						mismatches++;
					end
					if (ticks_left !== oldest.left) begin
						$error("ticks_left: expected %0d, got %0d", oldest.left, ticks_left);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		int         rand_base;
		int         phase;
		int         n_press;
		int         len;
		int         len_cap;
		cnt_t       lp;
		cnt_t       db;
		cnt_t       at;
		boot_path_t path;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_VALID_MASK;
		cfg_data    = '0;
		in_valid    = 1'b0;
		button_down = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: reset countdown, press edge, cursor walking and wrap,
		// empty mask, debounce and hold extremes, countdown restart.
		row_tick_lit(1'b0, RST_START_CURSOR, 1'b0, 1'b1, RST_AUTOBOOT);
		row_tick_lit(1'b0, RST_START_CURSOR, 1'b0, 1'b1, RST_AUTOBOOT - 16'd1);
		row_tick_lit(1'b1, RST_START_CURSOR, 1'b0, 1'b0, '0);
		row_tick_lit(1'b0, RST_START_CURSOR, 1'b0, 1'b0, '0);
		row_cfg(REG_DEBOUNCE, 16'd0);
		row_cfg(REG_LONG_PRESS, CNT_MAX);
		row_tick(1'b1);
		row_tick(1'b0);
		row_cfg(REG_VALID_MASK, 16'h0);
		row_tick_lit(1'b1, 2'd1, 1'b0, 1'b0, '0);
		row_tick_lit(1'b0, 2'd1, 1'b0, 1'b0, '0);
		row_cfg(REG_VALID_MASK, 16'h8);
		row_tick(1'b1);
		row_tick(1'b0);
		row_cfg(REG_START_CURSOR, 16'd3);
		row_cfg(REG_VALID_MASK, 16'hF);
		row_tick(1'b1);
		row_tick(1'b0);
		row_cfg(REG_DEBOUNCE, CNT_MAX);
		row_tick(1'b1);
		row_tick(1'b1);
		row_tick(1'b0);
		row_cfg(REG_DEBOUNCE, 16'd2);
		row_tick(1'b1);
		row_tick(1'b1);
		row_tick(1'b0);
		row_tick(1'b1);
		row_tick(1'b0);
		row_cfg(REG_AUTOBOOT, CNT_MAX);
		row_cfg(REG_AUTO_ENABLE, 16'd1);
		row_tick(1'b0);
		row_tick(1'b0);
		row_tick(1'b1);
		row_cfg(REG_AUTO_ENABLE, 16'd0);
		row_cfg(REG_AUTOBOOT, 16'd1);
		row_cfg(REG_LONG_PRESS, 16'd1);
		row_cfg(REG_DEBOUNCE, 16'd0);
		row_tick(1'b0);
		row_tick(1'b1);
		row_tick(1'b0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				set_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send_tick(dir_rows[i].down, dir_rows[i].lit, dir_rows[i].res);
		end

		// Random press sequences, one register setting per segment.
		rand_base = ticks_sent;
		while (ticks_sent - rand_base < RAND_TICKS) begin
			phase = (ticks_sent - rand_base) * 4 / RAND_TICKS;
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 66; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 66; end
				default: begin send_idle = 30; recv_stall = 30; end
			endcase

			set_reg(REG_VALID_MASK, 16'($urandom_range(0, 15)));
			if ($urandom_range(0, 3) == 0)
				set_reg(REG_START_CURSOR, 16'($urandom_range(0, 3)));
			case ($urandom_range(0, 5))
				0: db = '0;
				1: db = CNT_MAX;
				default: db = cnt_t'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 4))
				0: lp = CNT_MAX;
				1: lp = 16'd1;
				default: lp = cnt_t'($urandom_range(12, 40));
			endcase
			set_reg(REG_DEBOUNCE, db);
			set_reg(REG_LONG_PRESS, lp);
			// The countdown is kept far longer than the segment, so it never expires.
			if ($urandom_range(0, 2) == 0) begin
				at = ($urandom_range(0, 3) == 0) ? CNT_MAX : cnt_t'($urandom_range(300, 65535));
				set_reg(REG_AUTOBOOT, at);
				set_reg(REG_AUTO_ENABLE, 16'd1);
			end else if ($urandom_range(0, 1) == 1) begin
				set_reg(REG_AUTO_ENABLE, 16'd0);
			end

			// Presses never reach the hold threshold, so nothing boots here.
			len_cap = (lp < 16'd20) ? int'(lp) : 20;
			repeat ($urandom_range(0, 6))
				send_tick(1'b0, 1'b0, '0);
			if (lp >= 16'd30 && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(5, 30))
					send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				n_press = $urandom_range(1, 8);
				repeat (n_press) begin
					if ($urandom_range(0, 1) == 1)
						len = $urandom_range(1, len_cap);
					else
						len = int'(db) + int'($urandom_range(0, 2)) - 1;
					if (len < 1)
						len = 1;
					if (len > len_cap)
						len = len_cap;
					repeat (len)
						send_tick(1'b1, 1'b0, '0);
					repeat ($urandom_range(1, 5))
						send_tick(1'b0, 1'b0, '0);
				end
			end
			send_tick(1'b0, 1'b0, '0);
		end

		// The one boot of the run; the cursor slot may well be invalid.
		set_reg(REG_VALID_MASK, 16'($urandom_range(0, 15)));
		set_reg(REG_START_CURSOR, 16'($urandom_range(0, 3)));
		path = boot_path_t'($urandom_range(0, 3));
		case (path)
			BOOT_BY_HOLD: begin
				lp = cnt_t'($urandom_range(1, 20));
				set_reg(REG_LONG_PRESS, lp);
				repeat (int'(lp) + 1)
					send_tick(1'b1, 1'b0, '0);
			end
			BOOT_BY_TIMEOUT: begin
				at = ($urandom_range(0, 1) == 1) ? 16'd1 : cnt_t'($urandom_range(2, 30));
				set_reg(REG_AUTOBOOT, at);
				set_reg(REG_AUTO_ENABLE, 16'd1);
				repeat (int'(at) + 1)
					send_tick(1'b0, 1'b0, '0);
			end
			BOOT_ZERO_HOLD: begin
				set_reg(REG_LONG_PRESS, 16'd0);
				send_tick(1'b1, 1'b0, '0);
				send_tick(1'b1, 1'b0, '0);
			end
			default: begin
				set_reg(REG_AUTOBOOT, 16'd0);
				set_reg(REG_AUTO_ENABLE, 16'd1);
				send_tick(1'b0, 1'b0, '0);
			end
		endcase

		// Once halted the button and the loading writes have no effect.
		repeat ($urandom_range(8, 16))
			send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
		set_reg(REG_START_CURSOR, 16'($urandom_range(0, 3)));
		set_reg(REG_AUTO_ENABLE, 16'd1);
		repeat (8)
			send_tick(1'($urandom_range(0, 1)), 1'b0, '0);

		// Drain the results, then watch for strays.
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
